>>> hw/rtl/plnk_pkg.sv
package plnk_pkg;

  // Field widths
  localparam int CMD_W         = 3;
  localparam int POS_W         = 6;
  localparam int DATA_W        = 32;
  localparam int STAT_W        = 2;
  localparam int CNT_OUT_W     = 6;
  localparam int DEPTH_DEFAULT = 32;

  // Command codes; code 7 is a no-op
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_DEL_HEAD = 3'd3,
    CMD_DEL_TAIL = 3'd4,
    CMD_DEL_POS  = 3'd5,
    CMD_DUMP     = 3'd6
  } cmd_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_t;

endpackage

>>> hw/rtl/plnk_cell.sv
module plnk_cell #(
  parameter int IW    = 5,
  parameter int INDEX = 0
) (
  input  logic                                    clk,
  input  plnk_pkg::cell_op_t                      op,
  input  logic [IW-1:0]                           idx,
  input  logic [IW-1:0]                           last_idx,
  input  logic signed [plnk_pkg::DATA_W-1:0]      value,
  input  logic signed [plnk_pkg::DATA_W-1:0]      left_data,
  input  logic signed [plnk_pkg::DATA_W-1:0]      right_data,
  input  logic signed [plnk_pkg::DATA_W-1:0]      head_data,
  output logic signed [plnk_pkg::DATA_W-1:0]      data
);

  localparam logic [IW-1:0] MY = IW'(INDEX);

  // Insert shifts toward the tail, delete toward the head, rotate wraps
  // the head into the last occupied cell.
  always_ff @(posedge clk) begin
    case (op)
      plnk_pkg::OP_INS: begin
        if (MY == idx) data <= value;
        else if (MY > idx) data <= left_data;
      end
      plnk_pkg::OP_DEL: begin
        if (MY >= idx) data <= right_data;
      end
      plnk_pkg::OP_ROT: begin
        if (MY == last_idx) data <= head_data;
        else if (MY < last_idx) data <= right_data;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/positional_list_engine_top.sv
// Non-dump command: result is valid in the cycle after the request is taken;
// a new request can be taken every cycle while the result register drains.
// Dump of N entries: N results, one per cycle unless the receiver stalls, paced
// by the rotation of the cell chain; no request is taken meanwhile.
// Reset (synchronous, active high) clears the count and the handshake state;
// cell contents are not cleared.
module positional_list_engine_top #(
  parameter int DEPTH = plnk_pkg::DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic [plnk_pkg::CMD_W-1:0]             command,
  input  logic [plnk_pkg::POS_W-1:0]             position,
  input  logic signed [plnk_pkg::DATA_W-1:0]     value,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output logic [plnk_pkg::STAT_W-1:0]            status,
  output logic [plnk_pkg::CNT_OUT_W-1:0]         entry_count,
  output logic                                   item_valid,
  output logic signed [plnk_pkg::DATA_W-1:0]     item_data,
  output logic                                   last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((plnk_pkg::POS_W > CW) ? plnk_pkg::POS_W : CW) + 1;

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t                               state;
  logic [CW-1:0]                        cnt;
  logic [CW-1:0]                        cnt_next;
  logic [CW-1:0]                        rem;
  logic                                 out_free;
  logic                                 accept;
  logic                                 full;
  logic                                 empty;
  logic                                 start_dump;
  logic [PW-1:0]                        pos_w;
  logic [PW-1:0]                        cnt_w;
  logic [PW-1:0]                        pos_m1;
  logic [CW-1:0]                        cnt_m1;
  plnk_pkg::cell_op_t                   op;
  logic [IW-1:0]                        idx;
  plnk_pkg::status_t                    st;
  logic signed [plnk_pkg::DATA_W-1:0]   cell_q [DEPTH];

  // Handshake
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state == S_DUMP) || !out_free;
  assign accept    = req_valid && !req_stall;

  assign full   = (cnt == CW'(DEPTH));
  assign empty  = (cnt == '0);
  assign pos_w  = PW'(position);
  assign cnt_w  = PW'(cnt);
  assign pos_m1 = pos_w - PW'(1);
  assign cnt_m1 = cnt - CW'(1);

  // Command decode
  always_comb begin
    op         = plnk_pkg::OP_HOLD;
    idx        = '0;
    st         = plnk_pkg::ST_OK;
    cnt_next   = cnt;
    start_dump = 1'b0;
    if (accept) begin
      case (plnk_pkg::cmd_t'(command))
        plnk_pkg::CMD_INS_HEAD, plnk_pkg::CMD_INS_TAIL: begin
          if (full) begin
            st = plnk_pkg::ST_FULL;
          end else begin
            op       = plnk_pkg::OP_INS;
            idx      = (plnk_pkg::cmd_t'(command) == plnk_pkg::CMD_INS_HEAD) ?
                       '0 : cnt[IW-1:0];
            cnt_next = cnt + CW'(1);
          end
        end
        plnk_pkg::CMD_INS_POS: begin
          if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
            st = plnk_pkg::ST_INVALID;
          end else if (full) begin
            st = plnk_pkg::ST_FULL;
          end else begin
            op       = plnk_pkg::OP_INS;
            idx      = pos_m1[IW-1:0];
            cnt_next = cnt + CW'(1);
          end
        end
        plnk_pkg::CMD_DEL_HEAD, plnk_pkg::CMD_DEL_TAIL: begin
          if (empty) begin
            st = plnk_pkg::ST_EMPTY;
          end else begin
            op       = plnk_pkg::OP_DEL;
            idx      = (plnk_pkg::cmd_t'(command) == plnk_pkg::CMD_DEL_HEAD) ?
                       '0 : cnt_m1[IW-1:0];
            cnt_next = cnt_m1;
          end
        end
        plnk_pkg::CMD_DEL_POS: begin
          if (empty) begin
            st = plnk_pkg::ST_EMPTY;
          end else if (pos_w == '0 || pos_w > cnt_w) begin
            st = plnk_pkg::ST_INVALID;
          end else begin
            op       = plnk_pkg::OP_DEL;
            idx      = pos_m1[IW-1:0];
            cnt_next = cnt_m1;
          end
        end
        plnk_pkg::CMD_DUMP: begin
          start_dump = !empty;
        end
        default: ;
      endcase
    end else if (state == S_DUMP && out_free) begin
      op = plnk_pkg::OP_ROT;
    end
  end

  // Control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rem       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        if (start_dump) begin
          state     <= S_DUMP;
          rem       <= cnt;
          rsp_valid <= 1'b0;
        end else begin
          rsp_valid   <= 1'b1;
          status      <= st;
          entry_count <= plnk_pkg::CNT_OUT_W'(cnt_next);
          item_valid  <= 1'b0;
          item_data   <= '0;
          last        <= 1'b1;
        end
      end else if (state == S_DUMP && out_free) begin
        rsp_valid   <= 1'b1;
        status      <= plnk_pkg::ST_OK;
        entry_count <= plnk_pkg::CNT_OUT_W'(cnt);
        item_valid  <= 1'b1;
        item_data   <= cell_q[0];
        last        <= (rem == CW'(1));
        rem         <= rem - CW'(1);
        if (rem == CW'(1)) state <= S_IDLE;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [plnk_pkg::DATA_W-1:0] left_d;
    logic signed [plnk_pkg::DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    plnk_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .idx        (idx),
      .last_idx   (cnt_m1[IW-1:0]),
      .value      (value),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_q[0]),
      .data       (cell_q[i])
    );
  end

endmodule

>>> hw/rtl/plnk_checker.sv
module plnk_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   req_valid,
  input logic                                   req_stall,
  input logic [plnk_pkg::CMD_W-1:0]             command,
  input logic                                   rsp_valid,
  input logic                                   rsp_stall,
  input logic [plnk_pkg::STAT_W-1:0]            status,
  input logic [plnk_pkg::CNT_OUT_W-1:0]         entry_count,
  input logic                                   item_valid,
  input logic signed [plnk_pkg::DATA_W-1:0]     item_data,
  input logic                                   last
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
      $stable(entry_count) && $stable(item_valid) && $stable(item_data) && $stable(last))
    else $error("stalled result changed");

  // A dumped entry carries ok status; any entry count is accepted
  a_item: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && item_valid |-> status == plnk_pkg::ST_OK && entry_count != '0 ||
      rsp_valid && item_valid && entry_count == '0 && status == plnk_pkg::ST_OK)
    else $error("dump entry with bad status");

  // Any non-dump request answers in the next cycle
  a_single: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && command != plnk_pkg::CMD_DUMP |=> rsp_valid && last &&
      !item_valid)
    else $error("single result missing");

  // No new request while a dump is still streaming
  a_dump_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && item_valid && !last |-> req_stall)
    else $error("request taken during dump");

endmodule

bind positional_list_engine_top plnk_checker u_plnk_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .command     (command),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .status      (status),
  .entry_count (entry_count),
  .item_valid  (item_valid),
  .item_data   (item_data),
  .last        (last)
);

>>> bench/positional_list_engine_top_tb.sv
module positional_list_engine_top_tb;

  localparam int LIST_DEPTH = plnk_pkg::DEPTH_DEFAULT;
  localparam logic [plnk_pkg::CMD_W-1:0] CMD_NOOP = 3'd7;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic [plnk_pkg::CMD_W-1:0]         cmd;
    logic [plnk_pkg::POS_W-1:0]         pos;
    logic signed [plnk_pkg::DATA_W-1:0] val;
  } list_req_t;

  typedef struct {
    plnk_pkg::status_t                  status;
    logic [plnk_pkg::CNT_OUT_W-1:0]     cnt;
    logic                               iv;
    logic signed [plnk_pkg::DATA_W-1:0] data;
    logic                               fin;
  } list_rsp_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 req_valid = 1'b0;
  logic                                 req_stall;
  logic [plnk_pkg::CMD_W-1:0]           command = '0;
  logic [plnk_pkg::POS_W-1:0]           position = '0;
  logic signed [plnk_pkg::DATA_W-1:0]   value = '0;
  logic                                 rsp_valid;
  logic                                 rsp_stall = 1'b0;
  logic [plnk_pkg::STAT_W-1:0]          status;
  logic [plnk_pkg::CNT_OUT_W-1:0]       entry_count;
  logic                                 item_valid;
  logic signed [plnk_pkg::DATA_W-1:0]   item_data;
  logic                                 last;

  // pending requests and expected responses
  list_req_t pend_q[$];
  list_rsp_t resp_q[$];

  // shadow copy of the list
  logic signed [plnk_pkg::DATA_W-1:0] shadow_cells[LIST_DEPTH];
  int shadow_len = 0;

  // generator bookkeeping
  int gen_len = 0;
  bit growing = 1'b1;
  bit idle_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;

  // tallies
  int n_reqs = 0;
  int n_rsps = 0;
  int n_dumped = 0;
  int n_bad = 0;
  int n_stat[4] = '{0, 0, 0, 0};

  positional_list_engine_top #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .command    (command),
    .position   (position),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .entry_count(entry_count),
    .item_valid (item_valid),
    .item_data  (item_data),
    .last       (last)
  );

  always #10 clk = ~clk;

  function automatic void push_rsp(plnk_pkg::status_t st, logic iv,
                                   logic signed [plnk_pkg::DATA_W-1:0] d, logic fin);
    list_rsp_t r;
    r.status = st;
    r.cnt    = shadow_len[plnk_pkg::CNT_OUT_W-1:0];
    r.iv     = iv;
    r.data   = d;
    r.fin    = fin;
    resp_q.push_back(r);
  endfunction

  // apply one accepted request to the shadow list and queue its responses
  function automatic void apply_request(logic [plnk_pkg::CMD_W-1:0] cmd,
                                        logic [plnk_pkg::POS_W-1:0] pos,
                                        logic signed [plnk_pkg::DATA_W-1:0] val);
    plnk_pkg::status_t st;
    bit do_ins;
    bit do_del;
    int idx;
    int p;
    st = plnk_pkg::ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    idx = 0;
    p = int'(pos);
    if (cmd == plnk_pkg::CMD_DUMP) begin
      if (shadow_len == 0) push_rsp(plnk_pkg::ST_OK, 1'b0, '0, 1'b1);
      for (int i = 0; i < shadow_len; i++)
        push_rsp(plnk_pkg::ST_OK, 1'b1, shadow_cells[i], i == shadow_len - 1);
      return;
    end
    case (cmd)
      plnk_pkg::CMD_INS_HEAD: begin
        do_ins = 1'b1;
        idx = 0;
      end
      plnk_pkg::CMD_INS_TAIL: begin
        do_ins = 1'b1;
        idx = shadow_len;
      end
      plnk_pkg::CMD_INS_POS: begin
        // position is checked before fullness
        if (p < 1 || p > shadow_len + 1) st = plnk_pkg::ST_INVALID;
        else begin
          do_ins = 1'b1;
          idx = p - 1;
        end
      end
      plnk_pkg::CMD_DEL_HEAD: begin
        if (shadow_len == 0) st = plnk_pkg::ST_EMPTY;
        else begin
          do_del = 1'b1;
          idx = 0;
        end
      end
      plnk_pkg::CMD_DEL_TAIL: begin
        if (shadow_len == 0) st = plnk_pkg::ST_EMPTY;
        else begin
          do_del = 1'b1;
          idx = shadow_len - 1;
        end
      end
      plnk_pkg::CMD_DEL_POS: begin
        // empty wins over a bad position
        if (shadow_len == 0) st = plnk_pkg::ST_EMPTY;
        else if (p < 1 || p > shadow_len) st = plnk_pkg::ST_INVALID;
        else begin
          do_del = 1'b1;
          idx = p - 1;
        end
      end
      default: ;
    endcase
    if (do_ins) begin
      if (shadow_len >= LIST_DEPTH) st = plnk_pkg::ST_FULL;
      else begin
        for (int i = shadow_len; i > idx; i--) shadow_cells[i] = shadow_cells[i-1];
        shadow_cells[idx] = val;
        shadow_len++;
      end
    end
    if (do_del) begin
      for (int i = idx; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
      shadow_len--;
    end
    push_rsp(st, 1'b0, '0, 1'b1);
  endfunction

  // queue a request and track the list length it will leave behind
  function automatic void queue_req(logic [plnk_pkg::CMD_W-1:0] cmd,
                                    logic [plnk_pkg::POS_W-1:0] pos,
                                    logic signed [plnk_pkg::DATA_W-1:0] val);
    list_req_t r;
    int p;
    p = int'(pos);
    r.cmd = cmd;
    r.pos = pos;
    r.val = val;
    pend_q.push_back(r);
    case (cmd)
      plnk_pkg::CMD_INS_HEAD, plnk_pkg::CMD_INS_TAIL:
        if (gen_len < LIST_DEPTH) gen_len++;
      plnk_pkg::CMD_INS_POS:
        if (p >= 1 && p <= gen_len + 1 && gen_len < LIST_DEPTH) gen_len++;
      plnk_pkg::CMD_DEL_HEAD, plnk_pkg::CMD_DEL_TAIL:
        if (gen_len > 0) gen_len--;
      plnk_pkg::CMD_DEL_POS:
        if (gen_len > 0 && p >= 1 && p <= gen_len) gen_len--;
      default: ;
    endcase
  endfunction

  // mostly well-formed requests; the list swings between empty and full
  function automatic void random_req();
    logic [plnk_pkg::CMD_W-1:0] c;
    logic [plnk_pkg::POS_W-1:0] p;
    int pick;
    bit ins;
    pick = $urandom_range(0, 99);
    ins = 1'b0;
    if (pick < 4) c = plnk_pkg::CMD_DUMP;
    else if (pick < 6) c = CMD_NOOP;
    else if (pick < (growing ? 70 : 35)) begin
      ins = 1'b1;
      case ($urandom_range(0, 2))
        0: c = plnk_pkg::CMD_INS_HEAD;
        1: c = plnk_pkg::CMD_INS_TAIL;
        default: c = plnk_pkg::CMD_INS_POS;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: c = plnk_pkg::CMD_DEL_HEAD;
        1: c = plnk_pkg::CMD_DEL_TAIL;
        default: c = plnk_pkg::CMD_DEL_POS;
      endcase
    end
    if ($urandom_range(0, 9) == 0 || (!ins && gen_len == 0))
      p = plnk_pkg::POS_W'($urandom());
    else if (ins) p = plnk_pkg::POS_W'($urandom_range(1, gen_len + 1));
    else p = plnk_pkg::POS_W'($urandom_range(1, gen_len));
    queue_req(c, p, $urandom());
    if (gen_len == LIST_DEPTH) growing = 1'b0;
    else if (gen_len == 0) growing = 1'b1;
  endfunction

  // wait until every queued request is taken and every response is back
  task automatic wait_idle();
    do @(negedge clk); while (pend_q.size() != 0 || req_valid || resp_q.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    list_req_t r;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        apply_request(command, position, value);
        n_reqs++;
      end
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (idle_on && pend_q.size() != 0 && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 6);
          req_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          r = pend_q.pop_front();
          command   <= r.cmd;
          position  <= r.pos;
          value     <= r.val;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver stall
  always @(posedge clk) begin
    list_rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_rsps++;
      if (resp_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_SHOWN)
          $display("unexpected response: status %0d count %0d item %0b data %0d last %0b",
                   status, entry_count, item_valid, item_data, last);
      end else begin
        e = resp_q.pop_front();
        n_stat[status]++;
        if (item_valid) n_dumped++;
        if (status !== e.status || entry_count !== e.cnt || item_valid !== e.iv ||
            item_data !== e.data || last !== e.fin) begin
          n_bad++;
          if (n_bad <= MAX_SHOWN)
            $display({"mismatch on response %0d: exp st %0d cnt %0d iv %0b data %0d ",
                      "last %0b, got st %0d cnt %0d iv %0b data %0d last %0b"},
                     n_rsps, e.status, e.cnt, e.iv, e.data, e.fin,
                     status, entry_count, item_valid, item_data, last);
        end
      end
    end
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 6);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // run timeout
  initial begin
    #12_000_000;
    $display("positional_list_engine_top_tb: errors");
    $finish;
  end

  // stimulus
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty-list corners
    queue_req(plnk_pkg::CMD_DUMP, 6'd0, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_HEAD, 6'd0, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_TAIL, 6'd0, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_POS, 6'd0, 32'sd0);
    queue_req(plnk_pkg::CMD_INS_POS, 6'd0, 32'sd5);
    queue_req(plnk_pkg::CMD_INS_POS, 6'd2, 32'sd5);
    // build a short list through every insert kind
    queue_req(plnk_pkg::CMD_INS_HEAD, 6'd0, 32'h7fffffff);
    queue_req(plnk_pkg::CMD_INS_TAIL, 6'd0, 32'h80000000);
    queue_req(plnk_pkg::CMD_INS_POS, 6'd2, -32'sd1);
    queue_req(plnk_pkg::CMD_INS_POS, 6'd4, 32'sd0);
    queue_req(plnk_pkg::CMD_INS_POS, 6'd1, 32'h55555555);
    queue_req(plnk_pkg::CMD_INS_POS, 6'd63, 32'haaaaaaaa);
    queue_req(plnk_pkg::CMD_DUMP, 6'd0, 32'sd0);
    // positional delete out of range, then every delete kind
    queue_req(plnk_pkg::CMD_DEL_POS, 6'd0, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_POS, 6'd6, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_POS, 6'd63, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_POS, 6'd3, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_HEAD, 6'd0, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_TAIL, 6'd0, 32'sd0);
    queue_req(CMD_NOOP, 6'h2a, 32'h12345678);
    queue_req(plnk_pkg::CMD_DUMP, 6'd0, 32'sd0);
    wait_idle();

    // fill to full behind a long receiver hold, then probe the full list
    holds_asked++;
    while (gen_len < LIST_DEPTH) queue_req(plnk_pkg::CMD_INS_TAIL, 6'd0, $urandom());
    queue_req(plnk_pkg::CMD_INS_HEAD, 6'd0, 32'sd1);
    queue_req(plnk_pkg::CMD_INS_TAIL, 6'd0, 32'sd2);
    queue_req(plnk_pkg::CMD_INS_POS, 6'd33, 32'sd3);
    queue_req(plnk_pkg::CMD_INS_POS, 6'd1, 32'sd4);
    queue_req(plnk_pkg::CMD_INS_POS, 6'd34, 32'sd5);
    queue_req(plnk_pkg::CMD_DUMP, 6'd0, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_POS, 6'd32, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_POS, 6'd32, 32'sd0);
    queue_req(plnk_pkg::CMD_DEL_POS, 6'd1, 32'sd0);
    growing = 1'b0;
    wait_idle();

    // random traffic; the sender pauses until drained between parts
    repeat (130) random_req();
    wait_idle();
    repeat (80) random_req();
    wait_idle();
    // last part runs with no idling on either side
    idle_on = 1'b0;
    repeat (50) random_req();
    wait_idle();
    repeat (LIST_DEPTH + 8) @(negedge clk);

    if (resp_q.size() != 0) begin
      n_bad++;
      $display("%0d expected responses never arrived", resp_q.size());
    end
    $display("run covered %0d requests and %0d responses, %0d of them dumped entries",
             n_reqs, n_rsps, n_dumped);
    $display("status seen: ok %0d, empty %0d, invalid %0d, full %0d; %0d mismatches",
             n_stat[plnk_pkg::ST_OK], n_stat[plnk_pkg::ST_EMPTY],
             n_stat[plnk_pkg::ST_INVALID], n_stat[plnk_pkg::ST_FULL], n_bad);
    if (n_bad == 0) begin
      $display("positional_list_engine_top_tb: clean");
    end else begin
      $display("positional_list_engine_top_tb: errors");
    end
    $finish;
  end

endmodule
